### rtl/core/frustum_cull_test_top_macros.svh
// assertion macros shared by the frustum cull checker
`ifndef FRUSTUM_CULL_TEST_TOP_MACROS_SVH
`define FRUSTUM_CULL_TEST_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define FCT_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("frustum cull check failed");

// next-cycle implication, disabled during reset
`define FCT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("frustum cull check failed");

`endif

### rtl/core/fct_pkg.sv
// shared types, constants and tables of the frustum cull block
`timescale 1ns / 1ps

package fct_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int ELEM_W      = 32;
    localparam int SUM_W       = 33;
    localparam int LEN_W       = 33;
    localparam int RDC_W       = 66;
    localparam int SQRT_ITERS  = 33;
    localparam int NUM_REGS    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 64;
    localparam int NUM_PLANES  = 6;
    localparam int NUM_COEF    = 4;
    localparam int NUM_AXES    = 3;
    localparam int OPC_W       = 2;
    localparam int RADIUS_W    = 31;
    localparam int IN_TDATA_W  = 224;
    localparam int OUT_TDATA_W = 8;
    localparam int PLANE_W     = 3;
    localparam int COEF_IDX_W  = 2;
    localparam int COEF_ADDR_W = 5;
    localparam int CNT_W       = 6;

    typedef enum logic [OPC_W-1:0] {
        OP_POINT  = 2'd0,
        OP_SPHERE = 2'd1,
        OP_BOX    = 2'd2
    } opcode_t;

    // other matrix column used by a plane
    typedef enum logic [1:0] {
        COL_1 = 2'd0,
        COL_2 = 2'd1,
        COL_3 = 2'd2
    } col_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_D_LOAD,
        ST_D_SQ,
        ST_D_SQRT,
        ST_D_DIVI,
        ST_D_DIV,
        ST_D_WR,
        ST_T_INIT,
        ST_T_MAC,
        ST_T_CHK,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                  in_load;
        logic                  load_s;
        logic                  acc_clr;
        logic                  acc_add;
        logic                  sq_mul;
        logic                  sqrt_init;
        logic                  sqrt_step;
        logic                  div_init;
        logic                  div_step;
        logic                  coef_wr;
        logic                  set_valid;
        logic                  test_init;
        logic                  test_mul;
        logic                  test_chk;
        logic                  out_load;
        logic [PLANE_W-1:0]    plane;
        logic [COEF_IDX_W-1:0] idx;
    } fct_cmd_t;

    typedef struct packed {
        logic planes_valid;
    } fct_stat_t;

    // near, far, left, right, top, bottom
    function automatic col_sel_t plane_col(input logic [PLANE_W-1:0] p);
        col_sel_t c;
        case (p)
            3'd0, 3'd1: c = COL_3;
            3'd2, 3'd3: c = COL_1;
            default:    c = COL_2;
        endcase
        return c;
    endfunction

    function automatic logic plane_neg(input logic [PLANE_W-1:0] p);
        logic n;
        case (p)
            3'd1, 3'd3, 3'd4: n = 1'b1;
            default:          n = 1'b0;
        endcase
        return n;
    endfunction

    // identity matrix at reset
    function automatic logic [CFG_DATA_W-1:0] mat_reset(input int i);
        logic [CFG_DATA_W-1:0] v;
        case (i)
            0, 5:    v = 64'h0000_0000_0001_0000;
            2, 7:    v = 64'h0001_0000_0000_0000;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### rtl/core/frustum_cull_test_top.sv
// A test runs the 6 planes one after another on the shared multiply-accumulate unit,
// then loads the result into the output register; no new transaction is taken until
// then. After reset or a matrix write, the first test first derives the planes: per
// plane squares and a bit-serial sqrt, then a bit-serial divide for each of the 4
// coefficients. Reset restores the identity.
`timescale 1ns / 1ps

module frustum_cull_test_top
    import fct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pos_x, pos_y, pos_z, radius, box_max_x, box_max_y, box_max_z, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [OPC_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // culled, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    fct_cmd_t  cmd;
    fct_stat_t stat;
    logic      culled;

    // sequencer
    fct_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // datapath
    fct_dp #(
        .COORD_WIDTH (COORD_WIDTH),
        .FRAC_BITS   (FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_axis_tdata),
        .in_opcode (s_axis_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .culled    (culled)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, culled};

endmodule

### rtl/core/fct_ctrl.sv
// sequencer for plane derivation and per-transaction plane tests
`timescale 1ns / 1ps

module fct_ctrl
    import fct_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  fct_stat_t stat,
    output fct_cmd_t  cmd
);

    localparam int DIV_ITERS = SUM_W + FRAC_BITS;

    state_t                state_reg, state_next;
    logic [PLANE_W-1:0]    plane_reg, plane_next;
    logic [COEF_IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            plane_reg     <= '0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            plane_reg     <= plane_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        plane_next = plane_reg;
        idx_next   = idx_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                plane_next = '0;
                if (in_valid)
                    state_next = stat.planes_valid ? ST_T_INIT : ST_D_LOAD;
            end
            ST_D_LOAD:
            begin
                cnt_next   = '0;
                state_next = ST_D_SQ;
            end
            ST_D_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(4))
                begin
                    cnt_next   = '0;
                    state_next = ST_D_SQRT;
                end
            end
            ST_D_SQRT:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_ITERS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_D_DIVI;
                end
            end
            ST_D_DIVI:
            begin
                cnt_next   = '0;
                state_next = ST_D_DIV;
            end
            ST_D_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_ITERS - 1))
                    state_next = ST_D_WR;
            end
            ST_D_WR:
            begin
                if (idx_reg == COEF_IDX_W'(NUM_COEF - 1))
                begin
                    if (plane_reg == PLANE_W'(NUM_PLANES - 1))
                    begin
                        plane_next = '0;
                        state_next = ST_T_INIT;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                        state_next = ST_D_LOAD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_D_DIVI;
                end
            end
            ST_T_INIT:
            begin
                cnt_next   = '0;
                state_next = ST_T_MAC;
            end
            ST_T_MAC:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_AXES))
                    state_next = ST_T_CHK;
            end
            ST_T_CHK:
            begin
                if (plane_reg == PLANE_W'(NUM_PLANES - 1))
                    state_next = ST_OUT;
                else
                begin
                    plane_next = plane_reg + 1'b1;
                    state_next = ST_T_INIT;
                end
            end
            ST_OUT:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath commands and handshake
    always_comb
    begin
        cmd            = '0;
        cmd.plane      = plane_reg;
        cmd.idx        = idx_reg;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.in_load = in_valid;
            end
            ST_D_LOAD:
            begin
                cmd.load_s  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_D_SQ:
            begin
                cmd.idx       = cnt_reg[COEF_IDX_W-1:0];
                cmd.sq_mul    = cnt_reg < CNT_W'(NUM_AXES);
                cmd.acc_add   = (cnt_reg != '0) && (cnt_reg <= CNT_W'(NUM_AXES));
                cmd.sqrt_init = cnt_reg == CNT_W'(4);
            end
            ST_D_SQRT: cmd.sqrt_step = 1'b1;
            ST_D_DIVI: cmd.div_init = 1'b1;
            ST_D_DIV:  cmd.div_step = 1'b1;
            ST_D_WR:
            begin
                cmd.coef_wr   = 1'b1;
                cmd.set_valid = (idx_reg == COEF_IDX_W'(NUM_COEF - 1))
                             && (plane_reg == PLANE_W'(NUM_PLANES - 1));
            end
            ST_T_INIT: cmd.test_init = 1'b1;
            ST_T_MAC:
            begin
                cmd.idx      = cnt_reg[COEF_IDX_W-1:0];
                cmd.test_mul = cnt_reg < CNT_W'(NUM_AXES);
                cmd.acc_add  = cnt_reg != '0;
            end
            ST_T_CHK:  cmd.test_chk = 1'b1;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### rtl/core/fct_dp.sv
// datapath: matrix registers, plane store, shared multiplier, sqrt and divide
`timescale 1ns / 1ps

module fct_dp
    import fct_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_TDATA_W-1:0] in_data,
    input  logic [OPC_W-1:0]      in_opcode,
    input  fct_cmd_t              cmd,
    output fct_stat_t             stat,
    output logic                  culled
);

    localparam int CW    = COORD_WIDTH;
    localparam int MA    = (CW > SUM_W) ? CW : SUM_W;
    localparam int MB    = SUM_W;
    localparam int PW    = MA + MB;
    localparam int AW    = PW + 3;
    localparam int RW    = LEN_W + 4;
    localparam int DW    = SUM_W + FRAC_BITS;
    localparam int QX    = ((DW > CW) ? DW : CW) + 1;
    localparam int NCOEF = NUM_PLANES * NUM_COEF;

    localparam logic [QX-1:0] MAXP = (QX'(1) << (CW - 1)) - QX'(1);

    logic [CFG_DATA_W-1:0]  mat_reg [NUM_REGS];
    logic                   valid_reg;

    logic [OPC_W-1:0]       opc_reg;
    logic signed [ELEM_W-1:0] lo_reg [NUM_AXES];
    logic signed [ELEM_W-1:0] hi_reg [NUM_AXES];
    logic [RADIUS_W-1:0]    rad_reg;

    logic signed [SUM_W-1:0] s_reg [NUM_COEF];
    logic signed [SUM_W-1:0] s_next [NUM_COEF];
    logic signed [CW-1:0]    coef_reg [NCOEF];

    logic signed [PW-1:0]   prod_reg;
    logic signed [AW-1:0]   acc_reg;
    logic [RDC_W-1:0]       rdc_reg;
    logic [RW-1:0]          rem_reg;
    logic [LEN_W-1:0]       len_reg;
    logic [LEN_W:0]         drem_reg;
    logic [DW-1:0]          dq_reg;
    logic                   neg_reg;
    logic                   cull_reg;
    logic                   culled_reg;

    logic [COEF_ADDR_W-1:0] k_addr, d_addr, w_addr;
    logic signed [CW-1:0]   k_sel, d_sel;
    logic signed [ELEM_W-1:0] coord;
    logic signed [MA-1:0]   ma;
    logic signed [MB-1:0]   mb;
    logic [RW-1:0]          sq_t, sq_trial;
    logic [LEN_W:0]         dv_t;
    logic [SUM_W-1:0]       s_mag;
    logic [QX-1:0]          qx, q_sat;
    logic signed [CW-1:0]   coef_val;
    logic signed [AW-1:0]   init_val;
    logic                   opc_ok;

    // configuration registers and plane-valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                mat_reg[i] <= mat_reset(i);
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS)))
            begin
                mat_reg[cfg_index[2:0]] <= cfg_data;
                valid_reg               <= 1'b0;
            end
            else if (cmd.set_valid)
                valid_reg <= 1'b1;
        end
    end

    assign stat.planes_valid = valid_reg;

    // plane sums: column 4 plus or minus the other column, one per row
    always_comb
    begin
        for (int r = 0; r < NUM_COEF; r++)
        begin
            logic signed [SUM_W-1:0] c4, oc;
            c4 = SUM_W'($signed(mat_reg[2*r+1][63:32]));
            case (plane_col(cmd.plane))
                COL_1:   oc = SUM_W'($signed(mat_reg[2*r][31:0]));
                COL_2:   oc = SUM_W'($signed(mat_reg[2*r][63:32]));
                COL_3:   oc = SUM_W'($signed(mat_reg[2*r+1][31:0]));
                default: oc = '0;
            endcase
            s_next[r] = plane_neg(cmd.plane) ? c4 - oc : c4 + oc;
        end
    end

    // coefficient addressing
    assign k_addr = {cmd.plane, cmd.idx};
    assign d_addr = {cmd.plane, 2'd3};
    assign w_addr = {cmd.plane, cmd.idx};
    assign k_sel  = coef_reg[k_addr];
    assign d_sel  = coef_reg[d_addr];

    // box corner that maximizes the distance along this axis
    always_comb
    begin
        logic use_hi;
        use_hi = (opc_reg == OP_BOX)
              && ((k_sel >= 0) == (hi_reg[cmd.idx] >= lo_reg[cmd.idx]));
        coord  = use_hi ? hi_reg[cmd.idx] : lo_reg[cmd.idx];
    end

    // shared multiplier operands
    always_comb
    begin
        if (cmd.test_mul)
        begin
            ma = MA'(k_sel);
            mb = MB'(coord);
        end
        else
        begin
            ma = MA'(s_reg[cmd.idx]);
            mb = s_reg[cmd.idx];
        end
    end

    // accumulator start value for one plane test
    always_comb
    begin
        logic signed [AW-1:0] rad_term;
        rad_term = (opc_reg == OP_SPHERE)
                 ? (AW'($signed({1'b0, rad_reg})) <<< FRAC_BITS) : '0;
        init_val = (AW'(d_sel) <<< FRAC_BITS) + rad_term;
    end

    // restoring square root and divide steps
    assign sq_t     = {rem_reg[RW-3:0], rdc_reg[RDC_W-1 -: 2]};
    assign sq_trial = RW'({len_reg, 2'b01});
    assign dv_t     = {drem_reg[LEN_W-1:0], dq_reg[DW-1]};
    assign s_mag    = s_reg[cmd.idx][SUM_W-1] ? SUM_W'(-s_reg[cmd.idx])
                                              : SUM_W'(s_reg[cmd.idx]);

    // quotient saturation and sign
    always_comb
    begin
        qx = QX'(dq_reg);
        if (neg_reg)
            q_sat = (qx > MAXP + QX'(1)) ? MAXP + QX'(1) : qx;
        else
            q_sat = (qx > MAXP) ? MAXP : qx;
        if (len_reg == '0)
            coef_val = '0;
        else if (neg_reg)
            coef_val = CW'(QX'(0) - q_sat);
        else
            coef_val = CW'(q_sat);
    end

    always_comb
    begin
        case (opc_reg)
            OP_POINT, OP_SPHERE, OP_BOX: opc_ok = 1'b1;
            default:                     opc_ok = 1'b0;
        endcase
    end

    // control flags of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cull_reg   <= 1'b0;
            culled_reg <= 1'b0;
        end
        else
        begin
            if (cmd.in_load)
                cull_reg <= 1'b0;
            else if (cmd.test_chk && opc_ok && acc_reg[AW-1])
                cull_reg <= 1'b1;
            if (cmd.out_load)
                culled_reg <= cull_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            opc_reg   <= in_opcode;
            lo_reg[0] <= in_data[31:0];
            lo_reg[1] <= in_data[63:32];
            lo_reg[2] <= in_data[95:64];
            rad_reg   <= in_data[126:96];
            hi_reg[0] <= in_data[158:127];
            hi_reg[1] <= in_data[190:159];
            hi_reg[2] <= in_data[222:191];
        end
        if (cmd.load_s)
            for (int r = 0; r < NUM_COEF; r++)
                s_reg[r] <= s_next[r];
        if (cmd.sq_mul || cmd.test_mul)
            prod_reg <= ma * mb;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (cmd.test_init)
            acc_reg <= init_val;
        else if (cmd.acc_add)
            acc_reg <= acc_reg + AW'(prod_reg);
        if (cmd.sqrt_init)
        begin
            rdc_reg <= acc_reg[RDC_W-1:0];
            rem_reg <= '0;
            len_reg <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            rdc_reg <= {rdc_reg[RDC_W-3:0], 2'b00};
            if (sq_t >= sq_trial)
            begin
                rem_reg <= sq_t - sq_trial;
                len_reg <= {len_reg[LEN_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= sq_t;
                len_reg <= {len_reg[LEN_W-2:0], 1'b0};
            end
        end
        if (cmd.div_init)
        begin
            dq_reg   <= {s_mag, {FRAC_BITS{1'b0}}};
            drem_reg <= '0;
            neg_reg  <= s_reg[cmd.idx][SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            if (dv_t >= {1'b0, len_reg})
            begin
                drem_reg <= dv_t - {1'b0, len_reg};
                dq_reg   <= {dq_reg[DW-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dv_t;
                dq_reg   <= {dq_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.coef_wr)
            coef_reg[w_addr] <= coef_val;
    end

    assign culled = culled_reg;

endmodule

### rtl/core/fct_assert_mon.sv
// port-level assertions for the frustum cull block and their bind
`timescale 1ns / 1ps
`include "frustum_cull_test_top_macros.svh"

module fct_assert_mon
    import fct_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   cfg_we,
    input logic [CFG_IDX_W-1:0]   cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [OPC_W-1:0]       s_axis_tuser,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // one transaction in flight: input closes right after it is taken
    `FCT_ASSERT_NEXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a waiting result holds
    `FCT_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // only the culled bit is ever set
    `FCT_ASSERT_NOW(a_out_pad, clk, rst_n, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)

    // a result never appears the cycle after a transaction is taken
    `FCT_ASSERT_NOW(a_min_latency, clk, rst_n, $rose(m_axis_tvalid), !$past(s_axis_tvalid && s_axis_tready))

endmodule

bind frustum_cull_test_top fct_assert_mon u_assert_mon (.*);

### tb/testbench.sv
// self-checking testbench for the frustum cull block
`timescale 1ns / 1ps

module testbench;
    import fct_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum int {MAT_SMALL, MAT_FULL, MAT_MAX, MAT_MIN, MAT_ZERO} mat_kind_t;

    localparam int ONE_Q = 65536;

    typedef struct {
        logic [OPC_W-1:0]    op;
        int                  px;
        int                  py;
        int                  pz;
        bit [RADIUS_W-1:0]   rad;
        int                  bx;
        int                  by;
        int                  bz;
    } cull_item_t;

    // frustum predictor and queue of expected culled flags
    class CullScoreboard;
        bit [63:0] matrix [NUM_REGS];
        longint    coef [NUM_PLANES*NUM_COEF];
        bit        planes_ok;
        bit        cull_q [$];
        int        errors;

        function new();
            for (int i = 0; i < NUM_REGS; i++)
                matrix[i] = mat_reset(i);
            planes_ok = 0;
            errors = 0;
        endfunction

        function void set_reg(int idx, bit [63:0] val);
            if (idx < NUM_REGS)
            begin
                matrix[idx] = val;
                planes_ok = 0;
            end
        endfunction

        function longint elem(int r, int c);
            bit [63:0] rv;
            rv = matrix[(r - 1) * 2 + (c >= 3 ? 1 : 0)];
            return (c % 2 == 0) ? longint'(signed'(rv[63:32]))
                                : longint'(signed'(rv[31:0]));
        endfunction

        // planes are column 4 plus or minus column 3, 1 or 2
        function void extract_planes();
            int          other;
            bit          neg;
            longint      s [4];
            longint      q;
            logic [127:0] acc, mg, cand;
            logic [63:0] len, cc;
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                other = (p < 2) ? 3 : (p < 4) ? 1 : 2;
                neg = (p == 1 || p == 3 || p == 4);
                acc = '0;
                for (int r = 0; r < 4; r++)
                begin
                    s[r] = neg ? elem(r + 1, 4) - elem(r + 1, other)
                               : elem(r + 1, 4) + elem(r + 1, other);
                    if (r < 3)
                    begin
                        mg = (s[r] < 0) ? -s[r] : s[r];
                        acc = acc + mg * mg;
                    end
                end
                // exact integer square root
                len = '0;
                for (int b = 34; b >= 0; b--)
                begin
                    cc = len | (64'd1 << b);
                    cand = 128'(cc) * 128'(cc);
                    if (cand <= acc)
                        len = cc;
                end
                for (int r = 0; r < 4; r++)
                begin
                    if (len == 0)
                        coef[p*4+r] = 0;
                    else
                    begin
                        q = longint'(((s[r] < 0 ? -s[r] : s[r]) << 16) / len);
                        if (s[r] < 0)
                            coef[p*4+r] = (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
                        else
                            coef[p*4+r] = (q > 64'sd2147483647) ? 64'sd2147483647 : q;
                    end
                end
            end
            planes_ok = 1;
        endfunction

        function bit outside(int p, longint x, longint y, longint z, longint extra);
            logic signed [127:0] t, ka, kb, kc, kd, vx, vy, vz, ve;
            ka = coef[p*4];   kb = coef[p*4+1];
            kc = coef[p*4+2]; kd = coef[p*4+3];
            vx = x; vy = y; vz = z; ve = extra;
            t = ka * vx + kb * vy + kc * vz + (kd <<< 16) + ve;
            return t[127];
        endfunction

        function void note_test(cull_item_t it);
            bit     culled, all;
            longint lo [3], hi [3];
            culled = 0;
            lo[0] = it.px; lo[1] = it.py; lo[2] = it.pz;
            hi[0] = it.bx; hi[1] = it.by; hi[2] = it.bz;
            if (!planes_ok)
                extract_planes();
            for (int p = 0; p < NUM_PLANES && !culled; p++)
            begin
                if (it.op == OP_POINT)
                    culled = outside(p, lo[0], lo[1], lo[2], 0);
                else if (it.op == OP_SPHERE)
                    culled = outside(p, lo[0], lo[1], lo[2], longint'(it.rad) << 16);
                else if (it.op == OP_BOX)
                begin
                    all = 1;
                    for (int c = 0; c < 8 && all; c++)
                        all = outside(p, c[0] ? hi[0] : lo[0], c[1] ? hi[1] : lo[1],
                                      c[2] ? hi[2] : lo[2], 0);
                    culled = all;
                end
            end
            cull_q.push_back(culled);
        endfunction

        function void check_result(bit got);
            bit want;
            if (cull_q.size() == 0)
            begin
                $error("unexpected result transaction: culled=%0b", got);
                errors++;
            end
            else
            begin
                want = cull_q.pop_front();
                if (want != got)
                begin
                    $error("culled mismatch: expected %0b actual %0b", want, got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [OPC_W-1:0]       s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    CullScoreboard sb = new();
    idle_mode_t    mode = IDLE_NONE;

    frustum_cull_test_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // result side: random stalls and checking
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata[0]);
            if (mode == IDLE_RECV)
                m_axis_tready <= ($urandom_range(0, 99) >= 65);
            else if (mode == IDLE_BOTH)
                m_axis_tready <= ($urandom_range(0, 99) >= 18);
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic bit send_gap();
        if (mode == IDLE_SEND)
            return $urandom_range(0, 99) < 65;
        if (mode == IDLE_BOTH)
            return $urandom_range(0, 99) < 18;
        return 0;
    endfunction

    // one test transaction, with random leading gaps
    task automatic send_test(cull_item_t it);
        while (send_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.op;
        s_axis_tdata  <= {1'b0, it.bz, it.by, it.bx, it.rad, it.pz, it.py, it.px};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_test(it);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.cull_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // write enable stays high across back-to-back writes; the caller drops it
    task automatic write_reg(int idx, bit [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data  <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    function automatic int small_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return small_q(4 * ONE_Q);
        endcase
    endfunction

    function automatic bit [31:0] mat_elem(mat_kind_t k);
        case (k)
            MAT_SMALL: return small_q(2 * ONE_Q);
            MAT_FULL:  return $urandom;
            MAT_MAX:   return 32'h7fffffff;
            MAT_MIN:   return 32'h80000000;
            default:   return 32'h0;
        endcase
    endfunction

    function automatic cull_item_t rand_test();
        cull_item_t it;
        int r;
        r = $urandom_range(0, 19);
        it.op = (r == 0) ? 2'd3 : OP_POINT + (r % 3);
        it.px = rand_coord(); it.py = rand_coord(); it.pz = rand_coord();
        case ($urandom_range(0, 5))
            0: it.rad = $urandom;
            1: it.rad = 0;
            default: it.rad = $urandom_range(0, 3 * ONE_Q);
        endcase
        if ($urandom_range(0, 3) == 0)
        begin
            it.bx = rand_coord(); it.by = rand_coord(); it.bz = rand_coord();
        end
        else
        begin
            // well-formed box with a small extent
            it.bx = it.px + $urandom_range(0, 2 * ONE_Q);
            it.by = it.py + $urandom_range(0, 2 * ONE_Q);
            it.bz = it.pz + $urandom_range(0, 2 * ONE_Q);
        end
        return it;
    endfunction

    function automatic cull_item_t mk(logic [OPC_W-1:0] op, int x, int y, int z,
                                      bit [RADIUS_W-1:0] rad, int bx, int by, int bz);
        cull_item_t it;
        it.op = op; it.px = x; it.py = y; it.pz = z;
        it.rad = rad; it.bx = bx; it.by = by; it.bz = bz;
        return it;
    endfunction

    initial
    begin
        mat_kind_t kinds [6];
        kinds = '{MAT_SMALL, MAT_FULL, MAT_MAX, MAT_MIN, MAT_ZERO, MAT_SMALL};
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed tests against the reset identity matrix
        send_test(mk(OP_POINT, 0, 0, 0, 0, 0, 0, 0));
        send_test(mk(OP_POINT, 2 * ONE_Q, 0, 0, 0, 0, 0, 0));
        send_test(mk(OP_POINT, 0, -2 * ONE_Q, ONE_Q, 0, 0, 0, 0));
        send_test(mk(OP_POINT, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 0));
        send_test(mk(OP_POINT, 32'sh80000000, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0));
        send_test(mk(OP_POINT, -ONE_Q, ONE_Q, -ONE_Q, 0, 0, 0, 0));
        send_test(mk(OP_SPHERE, 3 * ONE_Q, 0, 0, ONE_Q, 0, 0, 0));
        send_test(mk(OP_SPHERE, 3 * ONE_Q, 0, 0, 3 * ONE_Q, 0, 0, 0));
        send_test(mk(OP_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_test(mk(OP_SPHERE, 32'sh80000000, 0, 0, 31'h7fffffff, 0, 0, 0));
        send_test(mk(OP_BOX, 2 * ONE_Q, 0, 0, 0, 3 * ONE_Q, ONE_Q, ONE_Q));
        send_test(mk(OP_BOX, -3 * ONE_Q, -ONE_Q, -ONE_Q, 0, 3 * ONE_Q, ONE_Q, ONE_Q));
        // inverted box, min above max
        send_test(mk(OP_BOX, 3 * ONE_Q, ONE_Q, ONE_Q, 0, 2 * ONE_Q, 0, 0));
        send_test(mk(OP_BOX, 32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h7fffffff,
                     32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_test(mk(2'd3, 9 * ONE_Q, 9 * ONE_Q, 9 * ONE_Q, 0, 0, 0, 0));
        send_test(mk(OP_POINT, -1, -1, -1, 31'h7fffffff, -1, -1, -1));

        // phases: new matrix, new idling pattern, random tests
        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            for (int i = 0; i < NUM_REGS; i++)
                write_reg(i, {mat_elem(kinds[ph]), mat_elem(kinds[ph])});
            if (ph == 1)
                write_reg(NUM_REGS + 3, 64'hffff_ffff_ffff_ffff);
            cfg_we <= 1'b0;
            mode = idle_mode_t'(ph % 4);
            for (int n = 0; n < 90; n++)
            begin
                if (ph == 2 && n == 45)
                begin
                    s_axis_tvalid <= 1'b0;
                    while (sb.cull_q.size() != 0)
                        @(posedge clk);
                end
                send_test(rand_test());
            end
        end

        drain();
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
